### rtl/core/ltok_pkg.sv
`default_nettype none
package ltok_pkg;

   localparam int unsigned MAX_TOKENS = 128;

   typedef enum logic [3:0] {
      MODE_IDLE    = 4'd0,
      MODE_IDENT   = 4'd1,
      MODE_ZERO    = 4'd2,
      MODE_HEXX    = 4'd3,
      MODE_HEX     = 4'd4,
      MODE_OCT     = 4'd5,
      MODE_DEC     = 4'd6,
      MODE_STR     = 4'd7,
      MODE_ESC     = 4'd8,
      MODE_SLASH   = 4'd9,
      MODE_COMMENT = 4'd10,
      MODE_SKIP    = 4'd11
   } lex_mode_type;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_INVALID  = 2'd1;
   localparam logic [1:0] ST_OVERFLOW = 2'd2;

   localparam logic [4:0] TY_PUNCT_BASE = 5'd10;
   localparam logic [4:0] TY_SLASH      = 5'd24;
   localparam logic [4:0] TY_STRING     = 5'd29;
   localparam logic [4:0] TY_INT        = 5'd30;
   localparam logic [4:0] TY_IDENT      = 5'd31;

   localparam logic [9:0] ALL_KW = 10'h3FF;

   localparam logic [7:0] CH_SLASH     = 8'h2F;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_DQUOTE    = 8'h22;
   localparam logic [7:0] CH_SQUOTE    = 8'h27;
   localparam logic [7:0] CH_X_LOWER   = 8'h78;
   localparam logic [7:0] CH_X_UPPER   = 8'h58;
   localparam logic [7:0] CH_NUL       = 8'h00;

   // keyword text, right-justified, zero padded
   localparam logic [63:0] KW_TEXT [10] = '{
      "if", "else", "do", "while", "break",
      "continue", "goto", "const", "extern", "volatile"
   };
   localparam logic [3:0] KW_LEN [10] = '{
      4'd2, 4'd4, 4'd2, 4'd5, 4'd5, 4'd8, 4'd4, 4'd5, 4'd6, 4'd8
   };

   typedef struct packed {
      lex_mode_type mode;
      logic         quote_dq;
      logic [9:0]   kw_cands;
      logic [3:0]   ident_len;
      logic [7:0]   toks;
      logic [15:0]  line_cnt;
      logic [1:0]   status;
   } lex_state_type;

   typedef struct packed {
      logic        ch_last;
      logic [7:0]  ch;
   } req_type;

   typedef struct packed {
      logic        prev_end;
      logic [4:0]  prev_type;
      logic        byte_kept;
      logic        token_start;
      logic        token_end;
      logic [4:0]  token_type;
      logic [7:0]  tok_byte;
      logic        line_done;
      logic [7:0]  token_count;
      logic [1:0]  status;
      logic [15:0] line_number;
   } rsp_type;

   function automatic logic is_space(input logic [7:0] c);
      return (c == 8'h20) || (c inside {[8'h09:8'h0D]});
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c inside {[8'h30:8'h39]};
   endfunction

   function automatic logic is_oct(input logic [7:0] c);
      return c inside {[8'h30:8'h37]};
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return (c inside {[8'h61:8'h7A]}) || (c inside {[8'h41:8'h5A]}) || (c == 8'h5F);
   endfunction

   function automatic logic is_hex(input logic [7:0] c);
      return is_digit(c) || (c inside {[8'h61:8'h66]}) || (c inside {[8'h41:8'h46]});
   endfunction

   // punctuator lookup: {hit, type}; slash is handled separately
   function automatic logic [5:0] punct_lookup(input logic [7:0] c);
      logic [5:0] r;
      r = '0;
      case (c)
         8'h3A:   r = {1'b1, 5'd10};
         8'h3B:   r = {1'b1, 5'd11};
         8'h2C:   r = {1'b1, 5'd12};
         8'h7B:   r = {1'b1, 5'd13};
         8'h7D:   r = {1'b1, 5'd14};
         8'h5B:   r = {1'b1, 5'd15};
         8'h5D:   r = {1'b1, 5'd16};
         8'h28:   r = {1'b1, 5'd17};
         8'h29:   r = {1'b1, 5'd18};
         8'h3D:   r = {1'b1, 5'd19};
         8'h21:   r = {1'b1, 5'd20};
         8'h2B:   r = {1'b1, 5'd21};
         8'h2D:   r = {1'b1, 5'd22};
         8'h2A:   r = {1'b1, 5'd23};
         8'h7C:   r = {1'b1, 5'd25};
         8'h5E:   r = {1'b1, 5'd26};
         8'h26:   r = {1'b1, 5'd27};
         8'h40:   r = {1'b1, 5'd28};
         default: r = '0;
      endcase
      return r;
   endfunction

   function automatic logic [9:0] kw_narrow(input logic [9:0] cands, input logic [3:0] pos,
                                             input logic [7:0] c);
      logic [9:0] r;
      int         idx;
      r = '0;
      if (pos < 4'd8) begin
         for (int k = 0; k < 10; k++) begin
            if (cands[k] && (pos < KW_LEN[k])) begin
               idx = int'(KW_LEN[k]) - 1 - int'(pos);
               if (KW_TEXT[k][idx*8 +: 8] == c) r[k] = 1'b1;
            end
         end
      end
      return r;
   endfunction

   function automatic logic [4:0] kw_type(input logic [9:0] cands, input logic [3:0] len);
      logic [4:0] t;
      t = TY_IDENT;
      for (int k = 9; k >= 0; k--) begin
         if (cands[k] && (KW_LEN[k] == len)) t = 5'(k);
      end
      return t;
   endfunction

endpackage
`default_nettype wire

### rtl/core/ltok_req_if.sv
`default_nettype none
interface ltok_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ch;
   logic       last_in_line;

   modport source (output valid, output ch, output last_in_line, input ready);
   modport sink (input valid, input ch, input last_in_line, output ready);
endinterface
`default_nettype wire

### rtl/core/ltok_rsp_if.sv
`default_nettype none
interface ltok_rsp_if;
   logic        valid;
   logic        ready;
   logic        prev_end;
   logic [4:0]  prev_type;
   logic        byte_kept;
   logic        token_start;
   logic        token_end;
   logic [4:0]  token_type;
   logic [7:0]  tok_byte;
   logic        line_done;
   logic [7:0]  token_count;
   logic [1:0]  status;
   logic [15:0] line_number;

   modport source (output valid, output prev_end, output prev_type, output byte_kept,
                   output token_start, output token_end, output token_type,
                   output tok_byte, output line_done, output token_count,
                   output status, output line_number, input ready);
   modport sink (input valid, input prev_end, input prev_type, input byte_kept,
                 input token_start, input token_end, input token_type,
                 input tok_byte, input line_done, input token_count,
                 input status, input line_number, output ready);
endinterface
`default_nettype wire

### rtl/core/ltok_step.sv
`default_nettype none
module ltok_step (
   input  ltok_pkg::lex_state_type state_cur,
   input  ltok_pkg::req_type       item,
   output ltok_pkg::lex_state_type state_nxt,
   output ltok_pkg::rsp_type       result
);

   ltok_pkg::lex_state_type s;
   ltok_pkg::rsp_type       r;
   logic                    do_fresh;
   logic [5:0]              pl;
   logic [4:0]              t;
   logic                    more;
   logic [7:0]              c;

   always_comb begin
      c        = item.ch;
      s        = state_cur;
      r        = '0;
      do_fresh = 1'b0;
      more     = 1'b0;
      t        = '0;
      pl       = ltok_pkg::punct_lookup(c);

      r.tok_byte    = c;
      r.line_number = state_cur.line_cnt + 16'd1;

      case (s.mode)
         ltok_pkg::MODE_IDLE: begin
            do_fresh = 1'b1;
         end
         ltok_pkg::MODE_SLASH: begin
            if (c == ltok_pkg::CH_SLASH) begin
               s.mode = ltok_pkg::MODE_COMMENT;
            end else begin
               s.mode = ltok_pkg::MODE_IDLE;
               t      = ltok_pkg::TY_SLASH;
               more   = 1'b1;
            end
         end
         ltok_pkg::MODE_IDENT: begin
            if (ltok_pkg::is_alpha(c) || ltok_pkg::is_digit(c)) begin
               s.kw_cands = ltok_pkg::kw_narrow(s.kw_cands, s.ident_len, c);
               if (s.ident_len != 4'd15) s.ident_len = s.ident_len + 4'd1;
               r.byte_kept  = 1'b1;
               r.token_type = ltok_pkg::TY_IDENT;
            end else begin
               t           = ltok_pkg::kw_type(s.kw_cands, s.ident_len);
               s.kw_cands  = ltok_pkg::ALL_KW;
               s.ident_len = '0;
               s.mode      = ltok_pkg::MODE_IDLE;
               more        = 1'b1;
            end
         end
         ltok_pkg::MODE_ZERO, ltok_pkg::MODE_HEXX, ltok_pkg::MODE_HEX,
         ltok_pkg::MODE_OCT, ltok_pkg::MODE_DEC: begin
            if ((s.mode == ltok_pkg::MODE_ZERO) &&
                ((c == ltok_pkg::CH_X_LOWER) || (c == ltok_pkg::CH_X_UPPER))) begin
               r.byte_kept  = 1'b1;
               r.token_type = ltok_pkg::TY_INT;
               s.mode       = ltok_pkg::MODE_HEXX;
            end else if (s.mode == ltok_pkg::MODE_HEXX) begin
               if (ltok_pkg::is_hex(c)) begin
                  r.byte_kept  = 1'b1;
                  r.token_type = ltok_pkg::TY_INT;
                  s.mode       = ltok_pkg::MODE_HEX;
               end else begin
                  s.status = ltok_pkg::ST_INVALID;
                  s.mode   = ltok_pkg::MODE_SKIP;
               end
            end else if ((s.mode == ltok_pkg::MODE_HEX) ? ltok_pkg::is_hex(c) :
                         (s.mode == ltok_pkg::MODE_DEC) ? ltok_pkg::is_digit(c) :
                         ltok_pkg::is_oct(c)) begin
               r.byte_kept  = 1'b1;
               r.token_type = ltok_pkg::TY_INT;
               if (s.mode == ltok_pkg::MODE_ZERO) s.mode = ltok_pkg::MODE_OCT;
            end else if (ltok_pkg::is_alpha(c)) begin
               s.status = ltok_pkg::ST_INVALID;
               s.mode   = ltok_pkg::MODE_SKIP;
            end else begin
               s.mode = ltok_pkg::MODE_IDLE;
               t      = ltok_pkg::TY_INT;
               more   = 1'b1;
            end
         end
         ltok_pkg::MODE_STR: begin
            if (c == ltok_pkg::CH_NUL) begin
               s.status = ltok_pkg::ST_INVALID;
               s.mode   = ltok_pkg::MODE_SKIP;
            end else begin
               r.byte_kept  = 1'b1;
               r.token_type = ltok_pkg::TY_STRING;
               if (c == ltok_pkg::CH_BACKSLASH) begin
                  s.mode = ltok_pkg::MODE_ESC;
               end else if (c == (s.quote_dq ? ltok_pkg::CH_DQUOTE : ltok_pkg::CH_SQUOTE)) begin
                  s.mode = ltok_pkg::MODE_IDLE;
                  if (s.toks >= 8'(ltok_pkg::MAX_TOKENS)) begin
                     s.status = ltok_pkg::ST_OVERFLOW;
                     s.mode   = ltok_pkg::MODE_SKIP;
                  end else begin
                     s.toks      = s.toks + 8'd1;
                     r.token_end = 1'b1;
                  end
               end
            end
         end
         ltok_pkg::MODE_ESC: begin
            if (c == ltok_pkg::CH_NUL) begin
               s.status = ltok_pkg::ST_INVALID;
               s.mode   = ltok_pkg::MODE_SKIP;
            end else begin
               r.byte_kept  = 1'b1;
               r.token_type = ltok_pkg::TY_STRING;
               s.mode       = ltok_pkg::MODE_STR;
            end
         end
         default: begin
         end
      endcase

      // pending token ends before this byte
      if (more) begin
         if (s.toks >= 8'(ltok_pkg::MAX_TOKENS)) begin
            s.status = ltok_pkg::ST_OVERFLOW;
            s.mode   = ltok_pkg::MODE_SKIP;
         end else begin
            s.toks      = s.toks + 8'd1;
            r.prev_end  = 1'b1;
            r.prev_type = t;
            do_fresh    = 1'b1;
         end
      end

      if (do_fresh) begin
         s.mode = ltok_pkg::MODE_IDLE;
         if (ltok_pkg::is_space(c)) begin
         end else if (c == ltok_pkg::CH_SLASH) begin
            r.byte_kept   = 1'b1;
            r.token_start = 1'b1;
            r.token_type  = ltok_pkg::TY_SLASH;
            s.mode        = ltok_pkg::MODE_SLASH;
         end else if (pl[5]) begin
            r.byte_kept   = 1'b1;
            r.token_start = 1'b1;
            r.token_type  = pl[4:0];
            if (s.toks >= 8'(ltok_pkg::MAX_TOKENS)) begin
               s.status = ltok_pkg::ST_OVERFLOW;
               s.mode   = ltok_pkg::MODE_SKIP;
            end else begin
               s.toks      = s.toks + 8'd1;
               r.token_end = 1'b1;
            end
         end else if ((c == ltok_pkg::CH_DQUOTE) || (c == ltok_pkg::CH_SQUOTE)) begin
            r.byte_kept   = 1'b1;
            r.token_start = 1'b1;
            r.token_type  = ltok_pkg::TY_STRING;
            s.quote_dq    = (c == ltok_pkg::CH_DQUOTE);
            s.mode        = ltok_pkg::MODE_STR;
         end else if (ltok_pkg::is_digit(c)) begin
            r.byte_kept   = 1'b1;
            r.token_start = 1'b1;
            r.token_type  = ltok_pkg::TY_INT;
            s.mode = (c == 8'h30) ? ltok_pkg::MODE_ZERO : ltok_pkg::MODE_DEC;
         end else if (ltok_pkg::is_alpha(c)) begin
            r.byte_kept   = 1'b1;
            r.token_start = 1'b1;
            r.token_type  = ltok_pkg::TY_IDENT;
            s.kw_cands    = ltok_pkg::kw_narrow(ltok_pkg::ALL_KW, 4'd0, c);
            s.ident_len   = 4'd1;
            s.mode        = ltok_pkg::MODE_IDENT;
         end else begin
            s.status = ltok_pkg::ST_INVALID;
            s.mode   = ltok_pkg::MODE_SKIP;
         end
      end

      if (item.ch_last) begin
         case (s.mode)
            ltok_pkg::MODE_IDENT, ltok_pkg::MODE_SLASH, ltok_pkg::MODE_ZERO,
            ltok_pkg::MODE_HEX, ltok_pkg::MODE_OCT, ltok_pkg::MODE_DEC: begin
               if (s.mode == ltok_pkg::MODE_IDENT)
                  t = ltok_pkg::kw_type(s.kw_cands, s.ident_len);
               else if (s.mode == ltok_pkg::MODE_SLASH)
                  t = ltok_pkg::TY_SLASH;
               else
                  t = ltok_pkg::TY_INT;
               if (s.toks >= 8'(ltok_pkg::MAX_TOKENS)) begin
                  s.status = ltok_pkg::ST_OVERFLOW;
               end else begin
                  s.toks       = s.toks + 8'd1;
                  r.token_end  = 1'b1;
                  r.token_type = t;
               end
            end
            ltok_pkg::MODE_HEXX, ltok_pkg::MODE_STR, ltok_pkg::MODE_ESC: begin
               s.status = ltok_pkg::ST_INVALID;
            end
            default: begin
            end
         endcase
         r.line_done   = 1'b1;
         r.token_count = s.toks;
         r.status      = s.status;
         s.mode        = ltok_pkg::MODE_IDLE;
         s.kw_cands    = ltok_pkg::ALL_KW;
         s.ident_len   = '0;
         s.quote_dq    = 1'b0;
         s.toks        = '0;
         s.status      = ltok_pkg::ST_OK;
         s.line_cnt    = s.line_cnt + 16'd1;
      end
   end

   assign state_nxt = s;
   assign result    = r;

endmodule
`default_nettype wire

### rtl/core/line_tokenizer_unit.sv
// Path: a transferred byte is held in the input register, and its result is then loaded
// into the result register, from which it is offered on the result channel.
// Throughput: one byte per cycle while results are taken; the per-byte lexer step is a
// single pass of combinational logic between the two registers. Input stalls only while
// both are full and the held result is not taken.
// Reset (synchronous, active high): lexer idle, line count zero, both stages empty.
`default_nettype none
module line_tokenizer_unit (
   input  wire         clock,
   input  wire         reset,
   ltok_req_if.sink    req_chan,
   ltok_rsp_if.source  rsp_chan
);

   logic                    in_valid_ff, in_valid_in;
   ltok_pkg::req_type       in_data_ff;
   logic                    out_valid_ff, out_valid_in;
   ltok_pkg::rsp_type       out_data_ff;
   ltok_pkg::lex_state_type state_ff, state_in;
   ltok_pkg::lex_state_type state_nxt;
   ltok_pkg::rsp_type       step_rsp;
   logic                    advance;
   logic                    fire_in;

   ltok_step u_step (
      .state_cur (state_ff),
      .item      (in_data_ff),
      .state_nxt (state_nxt),
      .result    (step_rsp)
   );

   assign advance        = !out_valid_ff || rsp_chan.ready;
   assign req_chan.ready = !in_valid_ff || advance;
   assign fire_in        = req_chan.valid && req_chan.ready;

   always_comb begin
      in_valid_in  = in_valid_ff;
      out_valid_in = out_valid_ff;
      state_in     = state_ff;
      if (advance) begin
         in_valid_in  = fire_in;
         out_valid_in = in_valid_ff;
         if (in_valid_ff) state_in = state_nxt;
      end else if (fire_in) begin
         in_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff       <= 1'b0;
         out_valid_ff      <= 1'b0;
         state_ff.mode      <= ltok_pkg::MODE_IDLE;
         state_ff.quote_dq  <= 1'b0;
         state_ff.kw_cands  <= ltok_pkg::ALL_KW;
         state_ff.ident_len <= '0;
         state_ff.toks      <= '0;
         state_ff.line_cnt  <= '0;
         state_ff.status    <= ltok_pkg::ST_OK;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire_in) begin
         in_data_ff.ch      <= req_chan.ch;
         in_data_ff.ch_last <= req_chan.last_in_line;
      end
      if (advance && in_valid_ff) begin
         out_data_ff <= step_rsp;
      end
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.prev_end    = out_data_ff.prev_end;
   assign rsp_chan.prev_type   = out_data_ff.prev_type;
   assign rsp_chan.byte_kept   = out_data_ff.byte_kept;
   assign rsp_chan.token_start = out_data_ff.token_start;
   assign rsp_chan.token_end   = out_data_ff.token_end;
   assign rsp_chan.token_type  = out_data_ff.token_type;
   assign rsp_chan.tok_byte    = out_data_ff.tok_byte;
   assign rsp_chan.line_done   = out_data_ff.line_done;
   assign rsp_chan.token_count = out_data_ff.token_count;
   assign rsp_chan.status      = out_data_ff.status;
   assign rsp_chan.line_number = out_data_ff.line_number;

   a_tok_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff.toks <= 8'(ltok_pkg::MAX_TOKENS))
      else $error("token count beyond limit");

   a_skip_status: assert property (@(posedge clock) disable iff (reset)
      state_ff.mode == ltok_pkg::MODE_SKIP |-> state_ff.status != ltok_pkg::ST_OK)
      else $error("skipping line without error status");

   a_count_done: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_data_ff.line_done |->
         out_data_ff.token_count == 8'd0 && out_data_ff.status == ltok_pkg::ST_OK)
      else $error("line summary outside line end");

   a_start_kept: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_data_ff.token_start |-> out_data_ff.byte_kept)
      else $error("token start on dropped byte");

   a_line_step: assert property (@(posedge clock) disable iff (reset)
      $past(!reset) && $past(advance && in_valid_ff && in_data_ff.ch_last) |->
         state_ff.line_cnt == $past(state_ff.line_cnt) + 16'd1)
      else $error("line counter not advanced at line end");

endmodule
`default_nettype wire

### dv/token_stream_checker.sv
module token_stream_checker
   import ltok_pkg::*;
(
   input  wire  clock,
   input  wire  reset,
   ltok_req_if  req_mon,
   ltok_rsp_if  rsp_mon,
   output int   fault_count,
   output int   marks_waiting
);

   string kw_words [10] = '{
      "if", "else", "do", "while", "break",
      "continue", "goto", "const", "extern", "volatile"
   };
   string punct_set = ":;,{}[]()=!+-*/|^&@";

   lex_mode_type mode;
   logic         quote_dq;
   logic [9:0]   kw_cands;
   logic [3:0]   id_len;
   logic [7:0]   toks;
   logic [15:0]  lines_done;
   logic [1:0]   line_st;

   rsp_type mark;
   rsp_type seen;
   rsp_type predicted_marks [$];

   function automatic bit is_blank(logic [7:0] c);
      return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
   endfunction

   function automatic bit is_num(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic bit is_letter(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
   endfunction

   function automatic bit is_hexdig(logic [7:0] c);
      return is_num(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
   endfunction

   function automatic logic [9:0] match_kw(logic [9:0] cands, logic [3:0] pos, logic [7:0] c);
      logic [9:0] r;
      r = '0;
      if (pos < 4'd8) begin
         for (int k = 0; k < 10; k++) begin
            if (cands[k] && int'(pos) < kw_words[k].len() && kw_words[k][pos] == c) r[k] = 1'b1;
         end
      end
      return r;
   endfunction

   function automatic logic [4:0] ident_kind();
      logic [4:0] ty;
      ty = TY_IDENT;
      for (int k = 0; k < 10; k++) begin
         if (ty == TY_IDENT && kw_cands[k] && kw_words[k].len() == int'(id_len)) ty = 5'(k);
      end
      return ty;
   endfunction

   function automatic void fail_line(logic [1:0] code);
      line_st = code;
      mode = MODE_SKIP;
   endfunction

   // token end report: prev-end for tokens seen to end on the following byte, else token-end
   function automatic bit accept_token(logic [4:0] ty, bit at_prev);
      if (int'(toks) >= MAX_TOKENS) begin
         fail_line(ST_OVERFLOW);
         return 1'b0;
      end
      toks++;
      if (at_prev) begin
         mark.prev_end = 1'b1;
         mark.prev_type = ty;
      end else begin
         mark.token_end = 1'b1;
         mark.token_type = ty;
      end
      return 1'b1;
   endfunction

   function automatic void keep(logic [4:0] ty);
      mark.byte_kept = 1'b1;
      mark.token_type = ty;
   endfunction

   function automatic void mark_start(logic [4:0] ty);
      keep(ty);
      mark.token_start = 1'b1;
   endfunction

   function automatic void fresh_byte(logic [7:0] c);
      mode = MODE_IDLE;
      if (is_blank(c)) return;
      if (c == CH_SLASH) begin
         mark_start(TY_SLASH);
         mode = MODE_SLASH;
         return;
      end
      for (int i = 0; i < 19; i++) begin
         if (punct_set[i] == c) begin
            mark_start(TY_PUNCT_BASE + 5'(i));
            void'(accept_token(TY_PUNCT_BASE + 5'(i), 1'b0));
            return;
         end
      end
      if (c == CH_DQUOTE || c == CH_SQUOTE) begin
         mark_start(TY_STRING);
         quote_dq = (c == CH_DQUOTE);
         mode = MODE_STR;
      end else if (is_num(c)) begin
         mark_start(TY_INT);
         mode = (c == "0") ? MODE_ZERO : MODE_DEC;
      end else if (is_letter(c)) begin
         mark_start(TY_IDENT);
         kw_cands = match_kw(ALL_KW, 4'd0, c);
         id_len = 4'd1;
         mode = MODE_IDENT;
      end else begin
         fail_line(ST_INVALID);
      end
   endfunction

   function automatic void number_step(logic [7:0] c);
      bit more;
      if (mode == MODE_ZERO && (c == CH_X_LOWER || c == CH_X_UPPER)) begin
         keep(TY_INT);
         mode = MODE_HEXX;
         return;
      end
      if (mode == MODE_HEXX) begin
         if (is_hexdig(c)) begin
            keep(TY_INT);
            mode = MODE_HEX;
         end else begin
            fail_line(ST_INVALID);
         end
         return;
      end
      case (mode)
         MODE_HEX: more = is_hexdig(c);
         MODE_DEC: more = is_num(c);
         default:  more = c >= "0" && c <= "7";
      endcase
      if (more) begin
         keep(TY_INT);
         if (mode == MODE_ZERO) mode = MODE_OCT;
      end else if (is_letter(c)) begin
         fail_line(ST_INVALID);
      end else begin
         mode = MODE_IDLE;
         if (accept_token(TY_INT, 1'b1)) fresh_byte(c);
      end
   endfunction

   function automatic rsp_type tokenize_byte(logic [7:0] c, logic last);
      logic [4:0] ty;
      mark = '0;
      mark.tok_byte = c;
      mark.line_number = lines_done + 16'd1;
      case (mode)
         MODE_IDLE: fresh_byte(c);
         MODE_SLASH: begin
            if (c == CH_SLASH) begin
               mode = MODE_COMMENT;
            end else begin
               mode = MODE_IDLE;
               if (accept_token(TY_SLASH, 1'b1)) fresh_byte(c);
            end
         end
         MODE_IDENT: begin
            if (is_letter(c) || is_num(c)) begin
               kw_cands = match_kw(kw_cands, id_len, c);
               if (id_len < 4'd15) id_len++;
               keep(TY_IDENT);
            end else begin
               ty = ident_kind();
               kw_cands = ALL_KW;
               id_len = '0;
               mode = MODE_IDLE;
               if (accept_token(ty, 1'b1)) fresh_byte(c);
            end
         end
         MODE_ZERO, MODE_HEXX, MODE_HEX, MODE_OCT, MODE_DEC: number_step(c);
         MODE_STR: begin
            if (c == CH_NUL) begin
               fail_line(ST_INVALID);
            end else begin
               keep(TY_STRING);
               if (c == CH_BACKSLASH) begin
                  mode = MODE_ESC;
               end else if (c == (quote_dq ? CH_DQUOTE : CH_SQUOTE)) begin
                  mode = MODE_IDLE;
                  void'(accept_token(TY_STRING, 1'b0));
               end
            end
         end
         MODE_ESC: begin
            if (c == CH_NUL) begin
               fail_line(ST_INVALID);
            end else begin
               keep(TY_STRING);
               mode = MODE_STR;
            end
         end
         default: ;
      endcase
      if (last) begin
         case (mode)
            MODE_IDENT: void'(accept_token(ident_kind(), 1'b0));
            MODE_SLASH: void'(accept_token(TY_SLASH, 1'b0));
            MODE_ZERO, MODE_HEX, MODE_OCT, MODE_DEC: void'(accept_token(TY_INT, 1'b0));
            MODE_HEXX, MODE_STR, MODE_ESC: fail_line(ST_INVALID);
            default: ;
         endcase
         mark.line_done = 1'b1;
         mark.token_count = toks;
         mark.status = line_st;
         mode = MODE_IDLE;
         kw_cands = ALL_KW;
         id_len = '0;
         quote_dq = 1'b0;
         toks = '0;
         line_st = ST_OK;
         lines_done++;
      end
      return mark;
   endfunction

   function automatic void check_mark(rsp_type got);
      rsp_type want;
      string   diffs;
      if (predicted_marks.size() == 0) begin
         fault_count++;
         if (fault_count <= 10) $display("[%0t] transfer with nothing outstanding: %p", $time, got);
         return;
      end
      want = predicted_marks.pop_front();
      diffs = "";
      if (got.prev_end !== want.prev_end) diffs = {diffs, " prev_end"};
      if (got.prev_type !== want.prev_type) diffs = {diffs, " prev_type"};
      if (got.byte_kept !== want.byte_kept) diffs = {diffs, " byte_kept"};
      if (got.token_start !== want.token_start) diffs = {diffs, " token_start"};
      if (got.token_end !== want.token_end) diffs = {diffs, " token_end"};
      if (got.token_type !== want.token_type) diffs = {diffs, " token_type"};
      if (got.tok_byte !== want.tok_byte) diffs = {diffs, " tok_byte"};
      if (got.line_done !== want.line_done) diffs = {diffs, " line_done"};
      if (got.token_count !== want.token_count) diffs = {diffs, " token_count"};
      if (got.status !== want.status) diffs = {diffs, " status"};
      if (got.line_number !== want.line_number) diffs = {diffs, " line_number"};
      if (diffs != "") begin
         fault_count++;
         if (fault_count <= 10) begin
            $display("[%0t] mismatch in%s", $time, diffs);
            $display("   expected %p", want);
            $display("   actual   %p", got);
         end
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         mode = MODE_IDLE;
         quote_dq = 1'b0;
         kw_cands = ALL_KW;
         id_len = '0;
         toks = '0;
         lines_done = '0;
         line_st = ST_OK;
         predicted_marks.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            seen = {rsp_mon.prev_end, rsp_mon.prev_type, rsp_mon.byte_kept, rsp_mon.token_start,
                    rsp_mon.token_end, rsp_mon.token_type, rsp_mon.tok_byte, rsp_mon.line_done,
                    rsp_mon.token_count, rsp_mon.status, rsp_mon.line_number};
            check_mark(seen);
         end
         if (req_mon.valid && req_mon.ready)
            predicted_marks.push_back(tokenize_byte(req_mon.ch, req_mon.last_in_line));
      end
      marks_waiting = predicted_marks.size();
   end

endmodule

### dv/tb_top.sv
module tb_top;
   import ltok_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int TAIL_CYCLES = 10;
   localparam int STREAM_BYTES = 900;
   localparam int HOLD_AT = 400;
   localparam int HOLD_CYCLES = 64;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   cyc = 0;
   int   fault_count;
   int   marks_waiting;

   req_type    byte_stream [$];
   logic [7:0] line_bytes [$];

   string keywords [10] = '{
      "if", "else", "do", "while", "break",
      "continue", "goto", "const", "extern", "volatile"
   };
   string crowd_tails [3] = '{"", "ab+c", " 7"};
   string letters = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
   string alnum = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
   string hexdigits = "0123456789abcdefABCDEF";
   string plain_punct = ":;,{}[]()=!+-*|^&@";

   ltok_req_if req_bus ();
   ltok_rsp_if rsp_bus ();

   line_tokenizer_unit uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   token_stream_checker marks_chk (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_bus),
      .rsp_mon       (rsp_bus),
      .fault_count   (fault_count),
      .marks_waiting (marks_waiting)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) cyc <= cyc + 1;

   function automatic bit calm_window();
      return cyc >= 800 && cyc < 1100;
   endfunction

   function automatic void put(logic [7:0] c);
      line_bytes.push_back(c);
   endfunction

   function automatic void put_text(string s);
      for (int i = 0; i < s.len(); i++) put(s[i]);
   endfunction

   function automatic logic [7:0] pick(string set);
      return set[$urandom_range(0, set.len() - 1)];
   endfunction

   function automatic void end_line();
      req_type it;
      if (line_bytes.size() == 0) put(8'h20);
      foreach (line_bytes[i]) begin
         it.ch = line_bytes[i];
         it.ch_last = (i == line_bytes.size() - 1);
         byte_stream.push_back(it);
      end
      line_bytes.delete();
   endfunction

   function automatic void put_string_lit();
      logic [7:0] q;
      logic [7:0] b;
      q = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
      put(q);
      repeat ($urandom_range(0, 6)) begin
         if ($urandom_range(0, 4) == 0) begin
            put(CH_BACKSLASH);
            put(8'($urandom_range(1, 255)));
         end else begin
            do b = 8'($urandom_range(1, 255)); while (b == q || b == CH_BACKSLASH);
            put(b);
         end
      end
      if ($urandom_range(0, 9) != 0) put(q);
   endfunction

   function automatic void put_token(int kind);
      string s;
      int    n;
      case (kind)
         0: put_text(keywords[$urandom_range(0, 9)]);
         1: begin
            s = keywords[$urandom_range(0, 9)];
            if ($urandom_range(0, 1)) begin
               put_text(s.substr(0, s.len() - 2));
            end else begin
               put_text(s);
               put(pick(alnum));
            end
         end
         2: begin
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 4);
            put(pick(letters));
            repeat (n - 1) put(pick(alnum));
         end
         3: begin
            put(pick("123456789"));
            repeat ($urandom_range(0, 4)) put(pick("0123456789"));
         end
         4: begin
            put("0");
            repeat ($urandom_range(0, 3)) put(pick("01234567"));
            if ($urandom_range(0, 3) == 0) put(pick("89"));
         end
         5: begin
            put("0");
            put(pick("xX"));
            repeat ($urandom_range(1, 4)) put(pick(hexdigits));
         end
         6: put(pick({plain_punct, "/"}));
         7: put_string_lit();
         8: begin
            put_text("//");
            repeat ($urandom_range(0, 6)) put(8'($urandom_range(1, 255)));
         end
         9: put(8'($urandom_range(1, 255)));
         default: begin
            // malformed numbers
            if ($urandom_range(0, 1)) begin
               put_text("12");
               put(pick(letters));
            end else begin
               put_text("0x");
               put(pick("gGzq_; "));
            end
         end
      endcase
   endfunction

   function automatic void random_line();
      int n;
      int r;
      int kind;
      int gap;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 30) : $urandom_range(1, 8);
      for (int t = 0; t < n; t++) begin
         r = $urandom_range(0, 99);
         kind = (r < 4) ? 9 : (r < 8) ? 10 : (r < 11) ? 8 : $urandom_range(0, 7);
         if (t > 0) begin
            gap = $urandom_range(0, 9);
            if (gap >= 4 && gap < 9) put(" ");
            else if (gap == 9) put(8'($urandom_range(9, 13)));
         end
         put_token(kind);
         if (kind == 8) break;
      end
      if ($urandom_range(0, 7) == 0) put(" ");
      end_line();
   endfunction

   function automatic void crowded_line(string tail);
      repeat (MAX_TOKENS) put(pick(plain_punct));
      put_text(tail);
      end_line();
   endfunction

   function automatic void build_stream();
      int lines;
      int crowds;
      put(8'h01); end_line();
      put(8'hFF); end_line();
      put_text("x/"); end_line();
      put_text("/b"); end_line();
      put_text("//z"); end_line();
      put_text("0x"); end_line();
      put_text("078;"); end_line();
      put_text("9a"); end_line();
      put_text("'\\''"); end_line();
      put_text("\"a"); end_line();
      lines = 0;
      crowds = 0;
      while (byte_stream.size() < STREAM_BYTES) begin
         if (lines % 10 == 5 && crowds < 3) begin
            crowded_line(crowd_tails[crowds]);
            crowds++;
         end else begin
            random_line();
         end
         lines++;
      end
   endfunction

   task automatic offer(req_type it);
      while (!calm_window() && $urandom_range(0, 99) < 28) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.ch <= it.ch;
      req_bus.last_in_line <= it.ch_last;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      @(negedge clock);
   endtask

   // result side: random back-pressure plus one long hold-off
   initial begin
      rsp_bus.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (cyc >= HOLD_AT && cyc < HOLD_AT + 2) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_bus.ready <= calm_window() || $urandom_range(0, 99) >= 28;
         @(negedge clock);
      end
   end

   initial begin
      while (cyc < CYCLE_LIMIT) @(posedge clock);
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      req_bus.valid = 1'b0;
      req_bus.ch = 8'h20;
      req_bus.last_in_line = 1'b0;
      build_stream();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      foreach (byte_stream[i]) offer(byte_stream[i]);
      req_bus.valid <= 1'b0;
      while (marks_waiting != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);
      if (fault_count == 0 && marks_waiting == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
